>>> hdl/psts_pkg.sv
`timescale 1ns / 1ps
package psts_pkg;

   localparam int RING_DEPTH_DEF  = 4096;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int TLEN_W  = 11;
   localparam int MINL_W  = 10;
   localparam int MAXL_W  = 11;
   localparam int RATIO_W = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 11;

   localparam logic [TLEN_W-1:0]  TLEN_RST  = 11'd441;
   localparam logic [MINL_W-1:0]  MINL_RST  = 10'd220;
   localparam logic [MAXL_W-1:0]  MAXL_RST  = 11'd882;
   localparam logic [RATIO_W-1:0] RATIO_RST = 11'd256;

   localparam logic [11:0] Q_MAX = 12'd4095;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMPLATE_LEN  = 2'd0,
      CSR_MIN_LAG       = 2'd1,
      CSR_MAX_LAG       = 2'd2,
      CSR_STRETCH_RATIO = 2'd3
   } csr_idx_type;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   // response tuser bit positions
   localparam int RSP_VALID_BIT = 0;
   localparam int RSP_OVF_BIT   = 1;
   localparam int RSP_DONE_BIT  = 2;
   localparam int RSP_USER_W    = 3;

endpackage

>>> hdl/pitch_sync_time_stretch_core.sv
`timescale 1ns / 1ps
// Pitch-synchronous time stretch core: a push (req_tuser = 0) before the end of stream stores
// one sample in the ring, or flags overflow when the ring is full, and returns its response
// through the report state; a pull (req_tuser = 1) returns the next stretched sample, or
// out_valid = 0 when the sample it needs has not arrived yet. A crossfaded pull ends in a
// bit-serial divide by the lag (SAMPLE_BITS + 11 steps). A pull that opens a segment first runs
// the lag search through the single shared multiply-accumulate unit, one product per cycle.
// One transaction is in work at a time; req_tready is low until its response is loaded.
// Configuration writes are taken at any time but must only be issued while the block is idle.
module pitch_sync_time_stretch_core #(
   parameter int RING_DEPTH  = psts_pkg::RING_DEPTH_DEF,
   parameter int SAMPLE_BITS = psts_pkg::SAMPLE_BITS_DEF,
   parameter int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [DATA_W-1:0]               req_tdata,   // sample_in
   input  logic                            req_tuser,   // op
   input  logic                            req_tlast,   // end_of_stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [DATA_W-1:0]               rsp_tdata,   // sample_out
   output logic [psts_pkg::RSP_USER_W-1:0] rsp_tuser,   // out_valid, overflow, stream_done
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [psts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psts_pkg::CSR_DAT_W-1:0]  csr_data
);

   localparam int AW   = $clog2(RING_DEPTH);
   localparam int SB   = SAMPLE_BITS;
   localparam int MW   = ((SB > 11) ? SB : 11) + 1;
   localparam int PW   = 2 * MW;
   localparam int ACCW = PW + 12;
   localparam int DW   = SB + 11;
   localparam int CW   = $clog2(DW + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH_ISSUE, S_SRCH_DRAIN, S_Q_MUL, S_Q_DONE, S_GEN_RD, S_GEN_DATA,
      S_XF_MUL1, S_XF_SUM, S_DIV_SET, S_DIV, S_DIV_END, S_FINISH, S_REPORT
   } state_type;

   state_type state_ff;

   logic [psts_pkg::TLEN_W-1:0]  tlen_ff;
   logic [psts_pkg::MINL_W-1:0]  minl_ff;
   logic [psts_pkg::MAXL_W-1:0]  maxl_ff;
   logic [psts_pkg::RATIO_W-1:0] ratio_ff;

   logic [31:0] recv_ff, start_ff, a_ff;
   logic [12:0] idx_ff;
   logic [10:0] lag_ff;
   logic [11:0] adv_ff;
   logic        active_ff, ended_ff;

   logic [SB-1:0] ring [RING_DEPTH];
   logic [SB-1:0] rd0_ff, rd1_ff;
   logic [AW-1:0] raddr0, raddr1, waddr;
   logic          push_wr;

   // search counters and pipeline
   logic [10:0]       m_ff, n_ff;
   logic              s1_vld_ff, s1_ok0_ff, s1_ok1_ff, s1_lastn_ff, s1_lastm_ff;
   logic [10:0]       s1_m_ff;
   logic              s2_vld_ff, s2_lastn_ff, s2_lastm_ff;
   logic [10:0]       s2_m_ff;
   logic [ACCW-1:0]   acc_ff, best_ff;

   // shared multiplier
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod_in, prod_ff;

   // pull generation
   logic          xf_ff, ok0_ff, ok1_ff;
   logic [10:0]   w0_ff, w1_ff;
   logic [SB-1:0] xv1_ff;
   logic [PW:0]   num_ff;
   logic          neg_ff;
   logic [10:0]   rem_ff;
   logic [DW-1:0] quo_ff;
   logic [CW-1:0] cnt_ff;

   logic [SB-1:0] sample_ff;
   logic          valid_ff, ovf_ff;
   logic          rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [psts_pkg::RSP_USER_W-1:0] rsp_user_ff;

   logic [31:0]   avail;
   logic [12:0]   need;
   logic [10:0]   lo;
   logic          req_fire, seg_go;
   logic [12:0]   off0, off1, k_plain, nn;
   logic          xf_sel;
   logic [SB-1:0] g0, g1;
   logic [11:0]   div_sh;
   logic [13:0]   idx_inc;
   logic [15:0]   q_rnd;
   logic [PW:0]   num_abs;

   assign avail    = recv_ff - start_ff;
   assign need     = {1'b0, maxl_ff, 1'b1};
   assign lo       = (minl_ff == '0) ? 11'd1 : {1'b0, minl_ff};
   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign push_wr  = req_fire && (req_tuser == psts_pkg::OP_PUSH) && !ended_ff &&
                     ($signed(avail) < $signed(32'(RING_DEPTH)));
   assign waddr    = recv_ff[AW-1:0];
   assign seg_go   = !active_ff && ($signed(avail) >= $signed({19'd0, need})) &&
                     (ended_ff ||
                      ($signed(avail) >= $signed({20'd0, tlen_ff, 1'b0} - 32'd1)));

   // offsets of the current output sample within the segment
   always_comb begin
      k_plain = idx_ff;
      nn      = idx_ff - {2'b0, lag_ff};
      xf_sel  = 1'b0;
      off0    = idx_ff;
      off1    = '0;
      if (idx_ff >= {2'b0, lag_ff}) begin
         if (nn < {2'b0, lag_ff}) begin
            xf_sel = 1'b1;
            off0   = {2'b0, lag_ff} + nn;
            off1   = nn;
         end else begin
            off0   = nn;
         end
      end else begin
         off0 = k_plain;
      end
   end

   always_comb begin
      raddr0 = '0;
      raddr1 = '0;
      if (state_ff == S_SRCH_ISSUE) begin
         raddr0 = AW'(start_ff + {21'd0, n_ff});
         raddr1 = AW'(start_ff + {21'd0, m_ff} + {21'd0, n_ff});
      end else begin
         raddr0 = AW'(start_ff + {19'd0, off0});
         raddr1 = AW'(start_ff + {19'd0, off1});
      end
   end

   always_ff @(posedge clock) begin
      if (push_wr) begin
         ring[waddr] <= req_tdata[SB-1:0];
      end
      rd0_ff <= ring[raddr0];
      rd1_ff <= ring[raddr1];
   end

   assign g0 = ok0_ff ? rd0_ff : '0;
   assign g1 = ok1_ff ? rd1_ff : '0;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SRCH_ISSUE, S_SRCH_DRAIN: begin
            mul_a = s1_ok0_ff ? MW'($signed(rd0_ff)) : '0;
            mul_b = s1_ok1_ff ? MW'($signed(rd1_ff)) : '0;
         end
         S_Q_MUL: begin
            mul_a = MW'(lag_ff);
            mul_b = MW'(ratio_ff);
         end
         S_GEN_DATA: begin
            mul_a = MW'($signed(g0));
            mul_b = MW'(w0_ff);
         end
         S_XF_MUL1: begin
            mul_a = MW'($signed(xv1_ff));
            mul_b = MW'(w1_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign div_sh  = {rem_ff, quo_ff[DW-1]};
   assign idx_inc = {1'b0, idx_ff} + 14'd1;
   assign q_rnd   = 16'((prod_ff[23:0] + 24'd128) >> 8);
   assign num_abs = num_ff[PW] ? (~num_ff + 1'b1) : num_ff;

   always_ff @(posedge clock) begin
      logic [ACCW-1:0] sum;
      sum = acc_ff + ACCW'(prod_ff);
      prod_ff <= prod_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         tlen_ff      <= psts_pkg::TLEN_RST;
         minl_ff      <= psts_pkg::MINL_RST;
         maxl_ff      <= psts_pkg::MAXL_RST;
         ratio_ff     <= psts_pkg::RATIO_RST;
         recv_ff      <= '0;
         start_ff     <= '0;
         idx_ff       <= '0;
         lag_ff       <= '0;
         adv_ff       <= '0;
         active_ff    <= 1'b0;
         ended_ff     <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (psts_pkg::csr_idx_type'(csr_index))
               psts_pkg::CSR_TEMPLATE_LEN:  tlen_ff  <= csr_data;
               psts_pkg::CSR_MIN_LAG:       minl_ff  <= csr_data[psts_pkg::MINL_W-1:0];
               psts_pkg::CSR_MAX_LAG:       maxl_ff  <= csr_data;
               psts_pkg::CSR_STRETCH_RATIO: ratio_ff <= csr_data;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != S_REPORT)) begin
            rsp_valid_ff <= 1'b0;
         end

         // search pipeline: read, multiply, accumulate
         s1_vld_ff   <= (state_ff == S_SRCH_ISSUE);
         s1_ok0_ff   <= $signed({21'd0, n_ff}) < $signed(a_ff);
         s1_ok1_ff   <= $signed({21'd0, m_ff} + {21'd0, n_ff}) < $signed(a_ff);
         s1_lastn_ff <= (n_ff == tlen_ff - 11'd1);
         s1_lastm_ff <= (m_ff == tlen_ff - 11'd1);
         s1_m_ff     <= m_ff;
         s2_vld_ff   <= s1_vld_ff;
         s2_lastn_ff <= s1_lastn_ff;
         s2_lastm_ff <= s1_lastm_ff;
         s2_m_ff     <= s1_m_ff;
         if (s2_vld_ff) begin
            if (s2_lastn_ff) begin
               acc_ff <= '0;
               if ($signed(sum) > $signed(best_ff)) begin
                  best_ff <= sum;
                  lag_ff  <= s2_m_ff;
               end
            end else begin
               acc_ff <= sum;
            end
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  valid_ff  <= 1'b0;
                  ovf_ff    <= 1'b0;
                  sample_ff <= '0;
                  a_ff      <= avail;
                  if (req_tuser == psts_pkg::OP_PUSH) begin
                     if (!ended_ff) begin
                        if (push_wr) begin
                           recv_ff <= recv_ff + 32'd1;
                        end else begin
                           ovf_ff <= 1'b1;
                        end
                        if (req_tlast) begin
                           ended_ff <= 1'b1;
                        end
                     end
                     state_ff <= S_REPORT;
                  end else if (seg_go) begin
                     lag_ff  <= lo;
                     best_ff <= '0;
                     acc_ff  <= '0;
                     m_ff    <= lo;
                     n_ff    <= '0;
                     state_ff <= (lo >= tlen_ff) ? S_Q_MUL : S_SRCH_ISSUE;
                  end else if (active_ff) begin
                     state_ff <= S_GEN_RD;
                  end else begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_SRCH_ISSUE: begin
               if (n_ff == tlen_ff - 11'd1) begin
                  n_ff <= '0;
                  if (m_ff == tlen_ff - 11'd1) begin
                     state_ff <= S_SRCH_DRAIN;
                  end else begin
                     m_ff <= m_ff + 11'd1;
                  end
               end else begin
                  n_ff <= n_ff + 11'd1;
               end
            end
            S_SRCH_DRAIN: begin
               if (s2_vld_ff && s2_lastn_ff && s2_lastm_ff) begin
                  state_ff <= S_Q_MUL;
               end
            end
            S_Q_MUL: begin
               state_ff <= S_Q_DONE;
            end
            S_Q_DONE: begin
               adv_ff    <= (q_rnd > 16'(psts_pkg::Q_MAX)) ? psts_pkg::Q_MAX : q_rnd[11:0];
               idx_ff    <= '0;
               active_ff <= 1'b1;
               state_ff  <= S_GEN_RD;
            end
            S_GEN_RD: begin
               xf_ff  <= xf_sel;
               ok0_ff <= $signed({19'd0, off0}) < $signed(a_ff);
               ok1_ff <= $signed({19'd0, off1}) < $signed(a_ff);
               w0_ff  <= lag_ff - nn[10:0];
               w1_ff  <= nn[10:0];
               state_ff <= S_GEN_DATA;
            end
            S_GEN_DATA: begin
               xv1_ff <= g1;
               if (!xf_ff) begin
                  valid_ff  <= ok0_ff || ended_ff;
                  sample_ff <= g0;
                  state_ff  <= S_FINISH;
               end else if ((ok0_ff || ended_ff) && (ok1_ff || ended_ff)) begin
                  state_ff <= S_XF_MUL1;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_XF_MUL1: begin
               num_ff   <= (PW + 1)'(prod_ff);
               state_ff <= S_XF_SUM;
            end
            S_XF_SUM: begin
               num_ff   <= num_ff + (PW + 1)'(prod_ff);
               state_ff <= S_DIV_SET;
            end
            S_DIV_SET: begin
               neg_ff   <= num_ff[PW];
               quo_ff   <= num_abs[DW-1:0];
               rem_ff   <= '0;
               cnt_ff   <= CW'(DW);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // restoring divide by the lag, one quotient bit per cycle
               if (div_sh >= {1'b0, lag_ff}) begin
                  rem_ff <= 11'(div_sh - {1'b0, lag_ff});
                  quo_ff <= {quo_ff[DW-2:0], 1'b1};
               end else begin
                  rem_ff <= div_sh[10:0];
                  quo_ff <= {quo_ff[DW-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  state_ff <= S_DIV_END;
               end
            end
            S_DIV_END: begin
               valid_ff  <= 1'b1;
               sample_ff <= neg_ff ? SB'(~quo_ff + 1'b1) : quo_ff[SB-1:0];
               state_ff  <= S_FINISH;
            end
            S_FINISH: begin
               if (valid_ff) begin
                  if (idx_inc >= {1'b0, 2'b0, lag_ff} + {2'b0, adv_ff}) begin
                     active_ff <= 1'b0;
                     start_ff  <= start_ff + {20'd0, adv_ff};
                     idx_ff    <= '0;
                  end else begin
                     idx_ff <= idx_inc[12:0];
                  end
               end
               state_ff <= S_REPORT;
            end
            S_REPORT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= DATA_W'(sample_ff);
                  rsp_user_ff[psts_pkg::RSP_VALID_BIT] <= valid_ff;
                  rsp_user_ff[psts_pkg::RSP_OVF_BIT]   <= ovf_ff;
                  rsp_user_ff[psts_pkg::RSP_DONE_BIT]  <= ended_ff && !active_ff &&
                     ($signed(avail) < $signed({19'd0, need}));
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> hdl/psts_checker.sv
`timescale 1ns / 1ps
module psts_checker #(
   parameter int SAMPLE_BITS = psts_pkg::SAMPLE_BITS_DEF,
   parameter int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [DATA_W-1:0]               rsp_tdata,
   input logic [psts_pkg::RSP_USER_W-1:0] rsp_tuser
);

   // a stalled response keeps its flags
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // a sample that is not produced reads as zero
   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[psts_pkg::RSP_VALID_BIT] |-> rsp_tdata == '0)
      else $error("nonzero sample without out_valid");

   // a push never yields a sample and a pull never overflows
   a_ovf_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[psts_pkg::RSP_VALID_BIT] && rsp_tuser[psts_pkg::RSP_OVF_BIT]))
      else $error("overflow together with out_valid");

   // one transaction in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

endmodule

bind pitch_sync_time_stretch_core psts_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_psts_checker (.*);

>>> tb/pitch_sync_time_stretch_core_tb.sv
`timescale 1ns / 1ps
module pitch_sync_time_stretch_core_tb;

   typedef struct packed {
      logic        op;
      logic [15:0] data;
      logic        last;
   } stream_item_type;

   typedef struct packed {
      logic [15:0] sample;
      logic        vld;
      logic        ovf;
      logic        done;
   } stretch_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = psts_pkg::OP_PUSH;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [psts_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [psts_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [psts_pkg::CSR_DAT_W-1:0] csr_data = '0;

   stream_item_type item_q[$];
   stretch_out_type stretched_q[$];
   stream_item_type nxt_item;
   stretch_out_type got;
   stretch_out_type want;
   bit steady = 1'b0;
   int errors = 0;
   int n_txn = 0, n_valid = 0, n_ovf = 0, n_done = 0;
   int wave_per = 8, wave_pos = 0;

   // shadow of the stretch engine
   logic signed [15:0] ring[4096];
   bit [31:0] rcv_count, seg_start, seg_idx, lag_p, adv_q;
   bit        seg_active, in_ended;
   int unsigned tlen, minl, maxl, ratio;

   pitch_sync_time_stretch_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint avail_now();
      return longint'($signed(rcv_count - seg_start));
   endfunction

   function automatic bit done_now();
      return in_ended && !seg_active && avail_now() < 2 * longint'(maxl) + 1;
   endfunction

   function automatic bit fetch_sample(input bit [31:0] off, input longint a,
                                       output longint v);
      bit [11:0] slot;
      slot = 12'(seg_start + off);
      if (longint'(off) < a) begin
         v = ring[slot];
         return 1'b1;
      end
      v = 0;
      return in_ended;
   endfunction

   function automatic void pick_lag(input longint a);
      bit [31:0] lo, m, n, q;
      longint best, acc, x0, x1;
      bit ok;
      lo = (minl != 0) ? minl : 1;
      lag_p = lo;
      best = 0;
      for (m = lo; m < tlen; m++) begin
         acc = 0;
         for (n = 0; n < tlen; n++) begin
            ok = fetch_sample(n, a, x0);
            ok = fetch_sample(m + n, a, x1);
            acc += x0 * x1;
         end
         if (acc > best) begin
            best = acc;
            lag_p = m;
         end
      end
      q = (lag_p * ratio + 128) >> 8;
      adv_q = (q > 4095) ? 4095 : q;
      seg_idx = 0;
      seg_active = 1'b1;
   endfunction

   function automatic void stretch_step(input logic op, input logic [15:0] din,
                                        input logic eos);
      longint a, need, v0, v1, s;
      bit ok0, ok1, vld;
      bit [31:0] n;
      stretch_out_type e;
      e = '0;
      s = 0;
      vld = 1'b0;
      need = 2 * longint'(maxl) + 1;
      if (op == psts_pkg::OP_PUSH) begin
         if (!in_ended) begin
            if (avail_now() >= 4096) begin
               e.ovf = 1'b1;
            end else begin
               ring[rcv_count[11:0]] = din;
               rcv_count++;
            end
            if (eos)
               in_ended = 1'b1;
         end
      end else begin
         a = avail_now();
         if (!seg_active && a >= need && (in_ended || a >= 2 * longint'(tlen) - 1))
            pick_lag(a);
         if (seg_active) begin
            if (seg_idx < lag_p) begin
               vld = fetch_sample(seg_idx, a, s);
            end else begin
               n = seg_idx - lag_p;
               if (n < lag_p) begin
                  ok0 = fetch_sample(lag_p + n, a, v0);
                  ok1 = fetch_sample(n, a, v1);
                  vld = ok0 && ok1;
                  s = (v0 * longint'(lag_p - n) + v1 * longint'(n)) / longint'(lag_p);
               end else begin
                  vld = fetch_sample(n, a, s);
               end
            end
            if (vld) begin
               seg_idx++;
               if (seg_idx >= lag_p + adv_q) begin
                  seg_active = 1'b0;
                  seg_start += adv_q;
                  seg_idx = 0;
               end
            end else begin
               s = 0;
            end
         end
      end
      e.sample = 16'(s);
      e.vld = vld;
      e.done = done_now();
      stretched_q.push_back(e);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            stretch_step(req_tuser, req_tdata, req_tlast);
            n_txn++;
         end
         if (!req_tvalid || req_tready) begin
            if (item_q.size() > 0 && (steady || $urandom_range(99) >= 15)) begin
               nxt_item = item_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= nxt_item.op;
               req_tdata <= nxt_item.data;
               req_tlast <= nxt_item.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= steady || ($urandom_range(99) >= 15);
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata, rsp_tuser[psts_pkg::RSP_VALID_BIT], rsp_tuser[psts_pkg::RSP_OVF_BIT],
                rsp_tuser[psts_pkg::RSP_DONE_BIT]};
         if (stretched_q.size() == 0) begin
            $display("%0t: unexpected transaction, got %h", $realtime, got);
            errors++;
         end else begin
            want = stretched_q.pop_front();
            if (got.sample !== want.sample) begin
               $display("%0t: sample_out expected %h got %h", $realtime, want.sample,
                        got.sample);
               errors++;
            end
            if (got.vld !== want.vld) begin
               $display("%0t: out_valid expected %b got %b", $realtime, want.vld, got.vld);
               errors++;
            end
            if (got.ovf !== want.ovf) begin
               $display("%0t: overflow expected %b got %b", $realtime, want.ovf, got.ovf);
               errors++;
            end
            if (got.done !== want.done) begin
               $display("%0t: stream_done expected %b got %b", $realtime, want.done,
                        got.done);
               errors++;
            end
            n_valid += want.vld;
            n_ovf += want.ovf;
            n_done += want.done;
         end
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (item_q.size() > 0 || req_tvalid || stretched_q.size() > 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input psts_pkg::csr_idx_type idx, input int unsigned val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[psts_pkg::CSR_DAT_W-1:0];
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         psts_pkg::CSR_TEMPLATE_LEN:  tlen = val & 11'h7ff;
         psts_pkg::CSR_MIN_LAG:       minl = val & 10'h3ff;
         psts_pkg::CSR_MAX_LAG:       maxl = val & 11'h7ff;
         psts_pkg::CSR_STRETCH_RATIO: ratio = val & 11'h7ff;
      endcase
   endtask

   task automatic set_config(input int unsigned t, input int unsigned mn,
                             input int unsigned mx, input int unsigned r);
      wait_idle();
      csr_write(psts_pkg::CSR_TEMPLATE_LEN, t);
      csr_write(psts_pkg::CSR_MIN_LAG, mn);
      csr_write(psts_pkg::CSR_MAX_LAG, mx);
      csr_write(psts_pkg::CSR_STRETCH_RATIO, r);
      wave_per = $urandom_range(2 * t + 2, 2);
   endtask

   task automatic push_item(input logic [15:0] d, input logic eos);
      item_q.push_back('{op: psts_pkg::OP_PUSH, data: d, last: eos});
   endtask

   task automatic pull_item();
      item_q.push_back('{op: psts_pkg::OP_PULL, data: 16'($urandom), last: 1'($urandom)});
   endtask

   // mix of a noisy square wave for the lag search and full-range values
   function automatic logic [15:0] pick_sample();
      int r, w;
      r = $urandom_range(99);
      wave_pos++;
      if (r < 8)
         return 16'h8000;
      if (r < 16)
         return 16'h7fff;
      if (r < 50)
         return 16'($urandom);
      w = ((wave_pos % wave_per) < wave_per / 2) ? 9000 : -9000;
      w = w + int'($urandom_range(400)) - 200;
      return 16'(w);
   endfunction

   task automatic random_part(input int count, input int push_pct);
      repeat (count) begin
         if ($urandom_range(99) < push_pct)
            push_item(pick_sample(), 1'b0);
         else
            pull_item();
      end
   endtask

   initial begin
      int b;
      rcv_count = 0; seg_start = 0; seg_idx = 0; lag_p = 0; adv_q = 0;
      seg_active = 0; in_ended = 0;
      tlen = 32'(psts_pkg::TLEN_RST);
      minl = 32'(psts_pkg::MINL_RST);
      maxl = 32'(psts_pkg::MAXL_RST);
      ratio = 32'(psts_pkg::RATIO_RST);
      foreach (ring[i]) ring[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: too few samples for any segment
      pull_item();
      push_item(16'h7fff, 1'b0);
      push_item(16'h8000, 1'b0);
      push_item(16'h0000, 1'b0);
      push_item(16'hffff, 1'b0);
      push_item(16'h0001, 1'b0);
      pull_item();
      push_item(16'h5555, 1'b0);
      push_item(16'haaaa, 1'b0);
      pull_item();
      pull_item();

      set_config(8, 1, 8, 256);
      random_part(150, 50);
      set_config(2, 0, 2, 2047);     // zero min lag reads as one
      random_part(150, 45);
      set_config(16, 4, 20, 1024);
      steady = 1'b1;
      random_part(120, 50);
      wait_idle();                   // hold off until all results are back
      random_part(80, 50);
      steady = 1'b0;
      set_config(32, 10, 40, 384);
      random_part(150, 50);
      set_config(200, 190, 200, 0);  // wide window, segments never advance
      repeat (420) push_item(pick_sample(), 1'b0);
      random_part(60, 20);
      set_config(12, 3, 12, 700);
      random_part(120, 40);
      set_config(24, 1, 30, 300);
      random_part(120, 45);

      // mark the end, then pushes that are ignored
      set_config(4, 3, 20, 2047);
      push_item(pick_sample(), 1'b1);
      push_item(pick_sample(), 1'b0);
      push_item(pick_sample(), 1'b1);
      for (b = 0; b < 6 && !done_now(); b++) begin
         repeat (16) pull_item();
         wait_idle();
      end
      // long lag search over a window that reads past the end as zeros
      set_config(600, 599, 0, 2047);
      repeat (40) pull_item();
      set_config(4, 3, 0, 2047);
      repeat (20) pull_item();
      wait_idle();
      repeat (50) @(posedge clock);

      $display("covered %0d transactions: %0d stretched samples, %0d dropped pushes,",
               n_txn, n_valid, n_ovf);
      $display("%0d responses after end of stream, over the reset and ten written settings",
               n_done);
      if (errors == 0)
         $display("PASS pitch_sync_time_stretch_core");
      else
         $display("FAIL pitch_sync_time_stretch_core");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("FAIL pitch_sync_time_stretch_core");
      $finish;
   end

endmodule
